FILE: rtl/cshp_pkg.sv
// types, codes and constants shared by the property set header parser
package cshp_pkg;

    localparam int MAX_LENGTH_BYTES_DEF = 4;
    localparam int HEADER_FIXED_BYTES   = 4;

    localparam logic [2:0] CLS_TYPE    = 3'd0;
    localparam logic [2:0] CLS_HEAD    = 3'd1;
    localparam logic [2:0] CLS_LENGTH  = 3'd2;
    localparam logic [2:0] CLS_MATCH   = 3'd3;
    localparam logic [2:0] CLS_PAYLOAD = 3'd4;

    localparam logic [1:0] KIND_UNDEF = 2'd0;
    localparam logic [1:0] KIND_ONE   = 2'd1;
    localparam logic [1:0] KIND_ALL   = 2'd2;

    localparam logic [3:0] NIB_ONE = 4'b0001;
    localparam logic [3:0] NIB_ALL = 4'b1111;

    typedef enum logic [5:0] {
        PH_TYPE    = 6'b000001,
        PH_HEAD    = 6'b000010,
        PH_LEN     = 6'b000100,
        PH_MATCH0  = 6'b001000,
        PH_MATCH1  = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  type_byte;
        logic [4:0]  elements;
        logic [2:0]  len_total;
        logic [1:0]  len_index;
        logic [31:0] len_accum;
        logic [15:0] mask;
        logic [31:0] payload_left;
    } parse_state_t;

    typedef struct packed {
        logic [2:0]  byte_class;
        logic [4:0]  element_count;
        logic [2:0]  length_bytes;
        logic [31:0] set_length;
        logic [1:0]  set_kind;
        logic [3:0]  parse_rule;
        logic [15:0] match_mask;
        logic        header_done;
        logic        set_done;
    } parse_result_t;

endpackage

FILE: rtl/cshp_step.sv
// per-byte next-state and result logic of the parser
module cshp_step
    import cshp_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
)
(
    input  parse_state_t  cur,
    input  logic [7:0]    byte_in,
    output parse_state_t  nxt,
    output parse_result_t res
);

    logic [2:0]  head_total;
    logic [1:0]  idx_inc;
    logic [32:0] hdr_len;
    logic [31:0] payload_dec;
    logic [3:0]  nib;

    always_comb
    begin
        head_total = {1'b0, byte_in[7:6]} + 3'd1;
        if (head_total > 3'(MAX_LENGTH_BYTES))
        begin
            head_total = 3'(MAX_LENGTH_BYTES);
        end
        idx_inc     = cur.len_index + 2'd1;
        hdr_len     = 33'(HEADER_FIXED_BYTES) + {30'd0, cur.len_total};
        payload_dec = (cur.payload_left != 32'd0) ? cur.payload_left - 32'd1 : 32'd0;

        nxt             = cur;
        res.byte_class  = CLS_TYPE;
        res.header_done = 1'b0;
        res.set_done    = 1'b0;

        unique case (cur.phase)
            PH_HEAD:
            begin
                res.byte_class = CLS_HEAD;
                nxt.elements   = {1'b0, byte_in[5:2]} + 5'd1;
                nxt.len_total  = head_total;
                nxt.len_index  = 2'd0;
                nxt.len_accum  = 32'd0;
                nxt.phase      = PH_LEN;
            end
            PH_LEN:
            begin
                res.byte_class = CLS_LENGTH;
                nxt.len_accum  = cur.len_accum | ({24'd0, byte_in} << {cur.len_index, 3'b000});
                nxt.len_index  = idx_inc;
                if (idx_inc == 2'd0 || {1'b0, idx_inc} >= cur.len_total)
                begin
                    nxt.phase = PH_MATCH0;
                end
            end
            PH_MATCH0:
            begin
                res.byte_class = CLS_MATCH;
                nxt.mask       = {8'd0, byte_in};
                nxt.phase      = PH_MATCH1;
            end
            PH_MATCH1:
            begin
                res.byte_class  = CLS_MATCH;
                res.header_done = 1'b1;
                nxt.mask        = {byte_in, cur.mask[7:0]};
                if ({1'b0, cur.len_accum} > hdr_len)
                begin
                    nxt.payload_left = cur.len_accum - hdr_len[31:0];
                    nxt.phase        = PH_PAYLOAD;
                end
                else
                begin
                    nxt.payload_left = 32'd0;
                    res.set_done     = 1'b1;
                    nxt.phase        = PH_TYPE;
                end
            end
            PH_PAYLOAD:
            begin
                res.byte_class   = CLS_PAYLOAD;
                nxt.payload_left = payload_dec;
                if (payload_dec == 32'd0)
                begin
                    res.set_done = 1'b1;
                    nxt.phase    = PH_TYPE;
                end
            end
            default:
            begin
                // type byte starts a new set
                res.byte_class   = CLS_TYPE;
                nxt.type_byte    = byte_in;
                nxt.elements     = 5'd1;
                nxt.len_total    = 3'd1;
                nxt.len_index    = 2'd0;
                nxt.len_accum    = 32'd0;
                nxt.mask         = 16'd0;
                nxt.payload_left = 32'd0;
                nxt.phase        = PH_HEAD;
            end
        endcase

        nib = nxt.type_byte[3:0];
        if (nib == NIB_ONE)
        begin
            res.set_kind = KIND_ONE;
        end
        else if (nib == NIB_ALL)
        begin
            res.set_kind = KIND_ALL;
        end
        else
        begin
            res.set_kind = KIND_UNDEF;
        end
        res.element_count = nxt.elements;
        res.length_bytes  = nxt.len_total;
        res.set_length    = nxt.len_accum;
        res.parse_rule    = nxt.type_byte[7:4];
        res.match_mask    = nxt.mask;
    end

endmodule

FILE: rtl/content_set_header_parser_top.sv
// property set header parser: input register, per-byte decode, result register
//
//  channel | signals                     | dir | content
//  in      | in_valid, in_stall, byte_in | in  | one raw byte of the set
//  out     | out_valid, out_stall, ...   | out | byte class and header fields
//
// one byte per cycle sustained while out is not stalled; a byte's result is presented
// after it passes the input register and then the result register with the parse state
// reset returns the parser to expecting a type byte, with the parse state at its start
// values (the result register is not reset); while out is stalled the input register
// still takes one request, then in_stall rises until the result is taken
module content_set_header_parser_top
    import cshp_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  byte_class,
    output logic [4:0]  element_count,
    output logic [2:0]  length_bytes,
    output logic [31:0] set_length,
    output logic [1:0]  set_kind,
    output logic [3:0]  parse_rule,
    output logic [15:0] match_mask,
    output logic        header_done,
    output logic        set_done
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg;
    parse_result_t res_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t res_next;
    logic          advance;

    assign advance  = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && !advance;

    cshp_step #(
        .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
    ) u_step (
        .cur     (state_reg),
        .byte_in (in_byte_reg),
        .nxt     (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            state_reg.phase        <= PH_TYPE;
            state_reg.type_byte    <= 8'd0;
            state_reg.elements     <= 5'd1;
            state_reg.len_total    <= 3'd1;
            state_reg.len_index    <= 2'd0;
            state_reg.len_accum    <= 32'd0;
            state_reg.mask         <= 16'd0;
            state_reg.payload_left <= 32'd0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            in_byte_reg <= byte_in;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte_class    = res_reg.byte_class;
    assign element_count = res_reg.element_count;
    assign length_bytes  = res_reg.length_bytes;
    assign set_length    = res_reg.set_length;
    assign set_kind      = res_reg.set_kind;
    assign parse_rule    = res_reg.parse_rule;
    assign match_mask    = res_reg.match_mask;
    assign header_done   = res_reg.header_done;
    assign set_done      = res_reg.set_done;

endmodule
